>>> design/tls_sni_extractor_core_assert.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef TLS_SNI_EXTRACTOR_CORE_ASSERT_SVH
`define TLS_SNI_EXTRACTOR_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/tse_pkg.sv
`default_nettype none

package tse_pkg;

  // Parser phases, one-hot.
  typedef enum logic [22:0] {
    PH_REC    = 23'd1 << 0,
    PH_RECHDR = 23'd1 << 1,
    PH_HSTYPE = 23'd1 << 2,
    PH_FIXED  = 23'd1 << 3,
    PH_SIDLEN = 23'd1 << 4,
    PH_SID    = 23'd1 << 5,
    PH_CSHI   = 23'd1 << 6,
    PH_CSLO   = 23'd1 << 7,
    PH_CS     = 23'd1 << 8,
    PH_CMLEN  = 23'd1 << 9,
    PH_CM     = 23'd1 << 10,
    PH_EXLHI  = 23'd1 << 11,
    PH_EXLLO  = 23'd1 << 12,
    PH_ETHI   = 23'd1 << 13,
    PH_ETLO   = 23'd1 << 14,
    PH_ELHI   = 23'd1 << 15,
    PH_ELLO   = 23'd1 << 16,
    PH_EXBODY = 23'd1 << 17,
    PH_SNIPRE = 23'd1 << 18,
    PH_NLHI   = 23'd1 << 19,
    PH_NLLO   = 23'd1 << 20,
    PH_NAME   = 23'd1 << 21,
    PH_DONE   = 23'd1 << 22
  } phase_t;

  // Protocol constants.
  localparam logic [7:0]  RECORD_HANDSHAKE = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO  = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME  = 16'h0000;
  localparam logic [15:0] RECHDR_SKIP      = 16'd4;
  // Handshake length (3), version (2) and the 32-byte random.
  localparam logic [15:0] FIXED_SKIP       = 16'd37;
  // Extension length (2), list length (2) and name type (1).
  localparam logic [15:0] SNIPRE_SKIP      = 16'd5;
  localparam logic [16:0] EXT_HDR_BYTES    = 17'd4;

  // Result kinds.
  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Result queue sizing.
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_IDX_BITS = 2;

  typedef struct packed {
    logic        kind;
    logic [7:0]  name_byte;
    logic        found;
    logic [15:0] name_offset;
    logic [15:0] name_length;
    logic        complete;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

>>> design/tls_sni_extractor_core.sv
// Channel  Direction  Ports                          Contents
// s        in         s_tvalid s_tready s_tdata      payload byte, tlast = last byte
//                     s_tlast
// m        out        m_tvalid m_tready m_tdata      name byte or verdict, tuser = kind,
//                     m_tuser m_tlast                tlast = verdict
//
// One input byte is accepted per cycle while s_tready is high; its results enter
// the output queue at the same clock edge and are offered on m from the queue.
// A byte yields at most two results (a name byte and the verdict), so the last
// byte of a packet that ends inside the name yields two output results.
// s_tready drops only when the four-entry output queue has fewer than two free
// slots, that is when m_tready has been held low.
// Reset (rst, synchronous) empties the queue and returns the parser to the
// record type byte.
`default_nettype none

module tls_sni_extractor_core #(
  parameter int POSITION_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [7:0]  s_tdata,   // [7:0] data_byte
  input  wire         s_tlast,   // last_byte
  output logic        m_tvalid,
  input  wire         m_tready,
  // [7:0] name_byte, [8] found, [24:9] name_offset, [40:25] name_length,
  // [41] complete, [47:42] zero
  output logic [47:0] m_tdata,
  output logic        m_tuser,   // kind
  output logic        m_tlast    // last
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  // Parser state.
  tse_pkg::phase_t          phase, phase_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [15:0]              skip, skip_next;
  logic [7:0]               hold, hold_next;
  logic [15:0]              ext_left, ext_left_next;
  logic                     found, found_next;
  logic [POSITION_BITS-1:0] saved_off, saved_off_next;
  logic [15:0]              saved_len, saved_len_next;

  logic                     accept;
  logic [15:0]              word;
  logic [16:0]              ext_cost;
  logic [15:0]              skip_dec;
  logic                     start_skip;
  tse_pkg::phase_t          start_phase;
  logic [15:0]              start_len;
  logic                     dec_skip;
  logic                     name_emit;
  tse_pkg::result_t         name_res;
  tse_pkg::result_t         verdict_res;
  tse_pkg::result_t         push_first;
  tse_pkg::result_t         push_second;
  logic [1:0]               push_count;
  logic                     space_ok;
  tse_pkg::result_t         out_res;

  // Phase that follows a finished skip.
  function automatic tse_pkg::phase_t after_skip(tse_pkg::phase_t ph, logic ext_empty);
    tse_pkg::phase_t r;
    unique case (ph)
      tse_pkg::PH_RECHDR: r = tse_pkg::PH_HSTYPE;
      tse_pkg::PH_FIXED:  r = tse_pkg::PH_SIDLEN;
      tse_pkg::PH_SID:    r = tse_pkg::PH_CSHI;
      tse_pkg::PH_CS:     r = tse_pkg::PH_CMLEN;
      tse_pkg::PH_CM:     r = tse_pkg::PH_EXLHI;
      tse_pkg::PH_EXBODY: r = ext_empty ? tse_pkg::PH_DONE : tse_pkg::PH_ETHI;
      tse_pkg::PH_SNIPRE: r = tse_pkg::PH_NLHI;
      default:            r = tse_pkg::PH_DONE;
    endcase
    return r;
  endfunction

  assign accept   = s_tvalid && s_tready;
  assign s_tready = space_ok;
  assign word     = {hold, s_tdata};
  assign ext_cost = {1'b0, word} + tse_pkg::EXT_HDR_BYTES;
  assign skip_dec = (skip != 16'd0) ? skip - 16'd1 : 16'd0;

  // Per-byte parser step.
  always_comb begin
    phase_next     = phase;
    skip_next      = skip;
    hold_next      = hold;
    ext_left_next  = ext_left;
    found_next     = found;
    saved_off_next = saved_off;
    saved_len_next = saved_len;
    start_skip     = 1'b0;
    start_phase    = tse_pkg::PH_DONE;
    start_len      = 16'd0;
    dec_skip       = 1'b0;
    name_emit      = 1'b0;

    unique case (phase)
      tse_pkg::PH_REC: begin
        if (s_tdata == tse_pkg::RECORD_HANDSHAKE) begin
          start_skip  = 1'b1;
          start_phase = tse_pkg::PH_RECHDR;
          start_len   = tse_pkg::RECHDR_SKIP;
        end else begin
          phase_next = tse_pkg::PH_DONE;
        end
      end
      tse_pkg::PH_HSTYPE: begin
        if (s_tdata == tse_pkg::HS_CLIENT_HELLO) begin
          start_skip  = 1'b1;
          start_phase = tse_pkg::PH_FIXED;
          start_len   = tse_pkg::FIXED_SKIP;
        end else begin
          phase_next = tse_pkg::PH_DONE;
        end
      end
      tse_pkg::PH_SIDLEN: begin
        start_skip  = 1'b1;
        start_phase = tse_pkg::PH_SID;
        start_len   = {8'd0, s_tdata};
      end
      tse_pkg::PH_CSHI: begin
        hold_next  = s_tdata;
        phase_next = tse_pkg::PH_CSLO;
      end
      tse_pkg::PH_CSLO: begin
        start_skip  = 1'b1;
        start_phase = tse_pkg::PH_CS;
        start_len   = word;
      end
      tse_pkg::PH_CMLEN: begin
        start_skip  = 1'b1;
        start_phase = tse_pkg::PH_CM;
        start_len   = {8'd0, s_tdata};
      end
      tse_pkg::PH_EXLHI: begin
        hold_next  = s_tdata;
        phase_next = tse_pkg::PH_EXLLO;
      end
      tse_pkg::PH_EXLLO: begin
        ext_left_next = word;
        phase_next    = (word == 16'd0) ? tse_pkg::PH_DONE : tse_pkg::PH_ETHI;
      end
      tse_pkg::PH_ETHI: begin
        hold_next  = s_tdata;
        phase_next = tse_pkg::PH_ETLO;
      end
      tse_pkg::PH_ETLO: begin
        if (word == tse_pkg::EXT_SERVER_NAME) begin
          start_skip  = 1'b1;
          start_phase = tse_pkg::PH_SNIPRE;
          start_len   = tse_pkg::SNIPRE_SKIP;
        end else begin
          phase_next = tse_pkg::PH_ELHI;
        end
      end
      tse_pkg::PH_ELHI: begin
        hold_next  = s_tdata;
        phase_next = tse_pkg::PH_ELLO;
      end
      tse_pkg::PH_ELLO: begin
        // The remaining extension bytes stop at zero rather than wrap.
        if (ext_cost >= {1'b0, ext_left}) begin
          ext_left_next = 16'd0;
        end else begin
          ext_left_next = ext_left - ext_cost[15:0];
        end
        start_skip  = 1'b1;
        start_phase = tse_pkg::PH_EXBODY;
        start_len   = word;
      end
      tse_pkg::PH_NLHI: begin
        hold_next  = s_tdata;
        phase_next = tse_pkg::PH_NLLO;
      end
      tse_pkg::PH_NLLO: begin
        found_next     = 1'b1;
        saved_len_next = word;
        saved_off_next = (pos == POS_MAX) ? POS_MAX : pos + POSITION_BITS'(1);
        start_skip     = 1'b1;
        start_phase    = tse_pkg::PH_NAME;
        start_len      = word;
      end
      tse_pkg::PH_NAME: begin
        name_emit = 1'b1;
        dec_skip  = 1'b1;
      end
      tse_pkg::PH_RECHDR, tse_pkg::PH_FIXED, tse_pkg::PH_SID, tse_pkg::PH_CS,
      tse_pkg::PH_CM, tse_pkg::PH_EXBODY, tse_pkg::PH_SNIPRE: begin
        dec_skip = 1'b1;
      end
      default: begin
        phase_next = tse_pkg::PH_DONE;
      end
    endcase

    // A zero-length field is passed over at once.
    if (start_skip) begin
      if (start_len == 16'd0) begin
        phase_next = after_skip(start_phase, ext_left_next == 16'd0);
        skip_next  = 16'd0;
      end else begin
        phase_next = start_phase;
        skip_next  = start_len;
      end
    end

    // Count down a skip or name field.
    if (dec_skip) begin
      if (skip_dec == 16'd0) begin
        phase_next = after_skip(phase, ext_left == 16'd0);
        skip_next  = 16'd0;
      end else begin
        skip_next = skip_dec;
      end
    end
  end

  assign pos_next = (pos == POS_MAX) ? pos : pos + POSITION_BITS'(1);

  // Results of this byte.
  always_comb begin
    name_res           = '0;
    name_res.kind      = tse_pkg::KIND_NAME;
    name_res.name_byte = s_tdata;

    verdict_res             = '0;
    verdict_res.kind        = tse_pkg::KIND_VERDICT;
    verdict_res.found       = found_next;
    verdict_res.name_offset = found_next ? 16'(saved_off_next) : 16'd0;
    verdict_res.name_length = found_next ? saved_len_next : 16'd0;
    verdict_res.complete    = found_next && (phase_next != tse_pkg::PH_NAME);
    verdict_res.last        = 1'b1;

    push_first  = name_emit ? name_res : verdict_res;
    push_second = verdict_res;
    push_count  = accept ? (2'(name_emit) + 2'(s_tlast)) : 2'd0;
  end

  // Parser registers; the packet end returns them to their start values.
  always_ff @(posedge clk) begin
    if (rst || (accept && s_tlast)) begin
      phase     <= tse_pkg::PH_REC;
      pos       <= '0;
      skip      <= '0;
      hold      <= '0;
      ext_left  <= '0;
      found     <= 1'b0;
      saved_off <= '0;
      saved_len <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      skip      <= skip_next;
      hold      <= hold_next;
      ext_left  <= ext_left_next;
      found     <= found_next;
      saved_off <= saved_off_next;
      saved_len <= saved_len_next;
    end
  end

  // Output queue decouples the two sides.
  tse_out_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (push_first),
    .push_second (push_second),
    .space_ok    (space_ok),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (out_res)
  );

  assign m_tdata = {6'd0, out_res.complete, out_res.name_length, out_res.name_offset,
                    out_res.found, out_res.name_byte};
  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last;

endmodule

`default_nettype wire

>>> design/tse_out_queue.sv
`default_nettype none

// Small result queue: up to two results written per cycle, one read per cycle while out_ready is high.
module tse_out_queue (
  input  wire                    clk,
  input  wire                    rst,
  input  wire  [1:0]             push_count,
  input  wire  tse_pkg::result_t push_first,
  input  wire  tse_pkg::result_t push_second,
  output logic                   space_ok,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tse_pkg::result_t       out_data
);

  localparam int IB = tse_pkg::QUEUE_IDX_BITS;

  tse_pkg::result_t slots [tse_pkg::QUEUE_DEPTH];
  logic [IB-1:0] head;
  logic [IB-1:0] tail;
  logic [IB:0]   count;
  logic          pop;

  // Room for two more results is required before taking an input item.
  assign space_ok  = count <= (IB+1)'(tse_pkg::QUEUE_DEPTH - 2);
  assign out_valid = count != '0;
  assign out_data  = slots[head];
  assign pop       = out_valid && out_ready;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (pop) begin
        head <= head + IB'(1);
      end
      tail  <= tail + IB'(push_count);
      count <= count + (IB+1)'(push_count) - (IB+1)'(pop);
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[tail] <= push_first;
    end
    if (push_count == 2'd2) begin
      slots[tail + IB'(1)] <= push_second;
    end
  end

endmodule

`default_nettype wire

>>> design/tse_checker.sv
`default_nettype none
`include "tls_sni_extractor_core_assert.svh"

// Port-level checks on the extractor.
module tse_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire [7:0]  s_tdata,
  input wire        s_tlast,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [47:0] m_tdata,
  input wire        m_tuser,
  input wire        m_tlast
);

  logic        stall;
  logic [49:0] m_word;
  logic        nofind;

  // Output side seen as one word, and the verdicts that found nothing.
  assign stall  = m_tvalid && !m_tready;
  assign m_word = {m_tlast, m_tuser, m_tdata};
  assign nofind = m_tvalid && m_tuser && !m_tdata[8];

  // A stalled result holds.
  `TSE_ASSERT_NEXT(a_out_hold, stall, m_tvalid && $stable(m_word), "stalled result changed")

  // Only a verdict closes a packet, and every verdict does.
  `TSE_ASSERT_SAME(a_verdict_last, m_tvalid, m_tuser == m_tlast, "kind and last disagree")

  // A not-found verdict carries no offset, length or completion.
  `TSE_ASSERT_SAME(a_notfound_zero, nofind, m_tdata[41:9] == 33'd0, "not-found verdict not zero")

  // With nothing waiting at the output, input is always taken.
  `TSE_ASSERT_SAME(a_ready_empty, !m_tvalid, s_tready, "input stalled with empty output")

  // The output is empty right after reset.
  `TSE_ASSERT_SAME(a_reset_empty, $past(rst), !m_tvalid, "result present after reset")

endmodule

bind tls_sni_extractor_core tse_checker u_checker (.*);

`default_nettype wire

>>> verif/tls_sni_extractor_core_test.sv
module tls_sni_extractor_core_test;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RANDOM_ITEMS  = 800;
  localparam int HOLD_CYCLES   = 600;
  localparam int DRAIN_CYCLES  = 20;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  // Verdict of a packet in which no server name was reached.
  localparam tse_pkg::result_t NO_SNI_VERDICT =
    '{tse_pkg::KIND_VERDICT, 8'h00, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b1};

  // One directed stimulus row. When typed is set, the row ends the packet and
  // its verdict is the plain no-find verdict; otherwise the predictor decides.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
  } dir_row_t;

  localparam int DIR_ROWS = 20;

  dir_row_t directed_rows [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1},   // not a handshake record, right after reset
    '{8'hFF, 1'b1, 1'b1},
    '{8'h16, 1'b1, 1'b1},   // packet ends after the record type
    '{8'h16, 1'b0, 1'b0},
    '{8'h03, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0},
    '{8'h00, 1'b0, 1'b0},
    '{8'h2A, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},   // wrong handshake type
    '{8'h55, 1'b1, 1'b1},
    '{8'h17, 1'b0, 1'b0},   // wrong record type, the rest is ignored
    '{8'h16, 1'b0, 1'b0},
    '{8'h01, 1'b1, 1'b1},
    '{8'h16, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},
    '{8'hFF, 1'b0, 1'b0},
    '{8'h01, 1'b0, 1'b0},   // client hello, then the packet ends in the random
    '{8'hAA, 1'b1, 1'b1}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] data_byte
  logic        s_tlast;    // last_byte
  logic        m_tvalid;
  logic        m_tready;
  // [7:0] name_byte, [8] found, [24:9] name_offset, [40:25] name_length,
  // [41] complete, [47:42] zero
  logic [47:0] m_tdata;
  logic        m_tuser;    // kind
  logic        m_tlast;    // last

  // Parser state of the predictor.
  tse_pkg::phase_t sni_phase;
  logic [15:0]     sni_pos;
  logic [15:0]     sni_skip;
  logic [7:0]      sni_hold;
  logic [16:0]     sni_ext_left;
  logic            sni_found;
  logic [15:0]     sni_offset;
  logic [15:0]     sni_length;

  tse_pkg::result_t expected_results [$];
  logic [7:0]       pkt_bytes [$];
  int               mismatches;
  int               sent_items;
  int               send_idle;
  int               recv_idle;
  logic             hold_req;
  logic             hold_off;

  tls_sni_extractor_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor: parser state back to the record type byte.
  function automatic void clear_sni_state();
    sni_phase    = tse_pkg::PH_REC;
    sni_pos      = '0;
    sni_skip     = '0;
    sni_hold     = '0;
    sni_ext_left = '0;
    sni_found    = 1'b0;
    sni_offset   = '0;
    sni_length   = '0;
  endfunction

  // Leave a skipping phase for the phase that follows it.
  function automatic void end_skip(input tse_pkg::phase_t ph);
    case (ph)
      tse_pkg::PH_RECHDR: sni_phase = tse_pkg::PH_HSTYPE;
      tse_pkg::PH_FIXED:  sni_phase = tse_pkg::PH_SIDLEN;
      tse_pkg::PH_SID:    sni_phase = tse_pkg::PH_CSHI;
      tse_pkg::PH_CS:     sni_phase = tse_pkg::PH_CMLEN;
      tse_pkg::PH_CM:     sni_phase = tse_pkg::PH_EXLHI;
      tse_pkg::PH_EXBODY: sni_phase = (sni_ext_left == '0) ? tse_pkg::PH_DONE
                                                           : tse_pkg::PH_ETHI;
      tse_pkg::PH_SNIPRE: sni_phase = tse_pkg::PH_NLHI;
      default:            sni_phase = tse_pkg::PH_DONE;
    endcase
    sni_skip = '0;
  endfunction

  // A zero-length field is passed over without consuming a byte.
  function automatic void start_skip(input tse_pkg::phase_t ph, input logic [15:0] n);
    if (n == '0) begin
      end_skip(ph);
    end else begin
      sni_phase = ph;
      sni_skip  = n;
    end
  endfunction

  // Predict the results of one accepted payload byte; returns their number.
  function automatic int predict_sni_step(input logic [7:0] b, input logic lb,
                                          output tse_pkg::result_t r0,
                                          output tse_pkg::result_t r1);
    logic [15:0]      word;
    int               n;
    tse_pkg::result_t verdict;
    word = {sni_hold, b};
    n    = 0;
    r0   = '0;
    r1   = '0;
    case (sni_phase)
      tse_pkg::PH_REC: begin
        if (b == tse_pkg::RECORD_HANDSHAKE) start_skip(tse_pkg::PH_RECHDR, tse_pkg::RECHDR_SKIP);
        else sni_phase = tse_pkg::PH_DONE;
      end
      tse_pkg::PH_HSTYPE: begin
        if (b == tse_pkg::HS_CLIENT_HELLO) start_skip(tse_pkg::PH_FIXED, tse_pkg::FIXED_SKIP);
        else sni_phase = tse_pkg::PH_DONE;
      end
      tse_pkg::PH_SIDLEN: start_skip(tse_pkg::PH_SID, {8'h00, b});
      tse_pkg::PH_CSHI, tse_pkg::PH_EXLHI, tse_pkg::PH_ETHI, tse_pkg::PH_ELHI,
      tse_pkg::PH_NLHI: begin
        sni_hold  = b;
        sni_phase = tse_pkg::phase_t'(sni_phase << 1);
      end
      tse_pkg::PH_CSLO:  start_skip(tse_pkg::PH_CS, word);
      tse_pkg::PH_CMLEN: start_skip(tse_pkg::PH_CM, {8'h00, b});
      tse_pkg::PH_EXLLO: begin
        sni_ext_left = {1'b0, word};
        sni_phase    = (word == '0) ? tse_pkg::PH_DONE : tse_pkg::PH_ETHI;
      end
      tse_pkg::PH_ETLO: begin
        if (word == tse_pkg::EXT_SERVER_NAME) begin
          start_skip(tse_pkg::PH_SNIPRE, tse_pkg::SNIPRE_SKIP);
        end else begin
          sni_phase = tse_pkg::PH_ELHI;
        end
      end
      tse_pkg::PH_ELLO: begin
        // The extension count stops at zero instead of wrapping.
        if ({1'b0, word} + tse_pkg::EXT_HDR_BYTES >= sni_ext_left) begin
          sni_ext_left = '0;
        end else begin
          sni_ext_left = sni_ext_left - ({1'b0, word} + tse_pkg::EXT_HDR_BYTES);
        end
        start_skip(tse_pkg::PH_EXBODY, word);
      end
      tse_pkg::PH_NLLO: begin
        sni_found  = 1'b1;
        sni_length = word;
        sni_offset = (sni_pos == POS_MAX) ? POS_MAX : sni_pos + 16'd1;
        start_skip(tse_pkg::PH_NAME, word);
      end
      tse_pkg::PH_NAME: begin
        r0.kind      = tse_pkg::KIND_NAME;
        r0.name_byte = b;
        n            = 1;
        sni_skip     = sni_skip - 16'd1;
        if (sni_skip == '0) end_skip(tse_pkg::PH_NAME);
      end
      tse_pkg::PH_RECHDR, tse_pkg::PH_FIXED, tse_pkg::PH_SID, tse_pkg::PH_CS,
      tse_pkg::PH_CM, tse_pkg::PH_EXBODY, tse_pkg::PH_SNIPRE: begin
        if (sni_skip != '0) sni_skip = sni_skip - 16'd1;
        if (sni_skip == '0) end_skip(sni_phase);
      end
      default: sni_phase = tse_pkg::PH_DONE;
    endcase

    // The byte position saturates on long packets.
    if (sni_pos != POS_MAX) sni_pos = sni_pos + 16'd1;

    if (lb) begin
      verdict             = '0;
      verdict.kind        = tse_pkg::KIND_VERDICT;
      verdict.found       = sni_found;
      verdict.name_offset = sni_found ? sni_offset : 16'h0000;
      verdict.name_length = sni_found ? sni_length : 16'h0000;
      verdict.complete    = sni_found && (sni_phase != tse_pkg::PH_NAME);
      verdict.last        = 1'b1;
      if (n == 0) r0 = verdict;
      else r1 = verdict;
      n++;
      clear_sni_state();
    end
    return n;
  endfunction

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_result(input tse_pkg::result_t got, input tse_pkg::result_t want);
    if (got.kind !== want.kind)
      report_mismatch("kind", 16'(got.kind), 16'(want.kind));
    if (got.name_byte !== want.name_byte)
      report_mismatch("name_byte", 16'(got.name_byte), 16'(want.name_byte));
    if (got.found !== want.found)
      report_mismatch("found", 16'(got.found), 16'(want.found));
    if (got.name_offset !== want.name_offset)
      report_mismatch("name_offset", got.name_offset, want.name_offset);
    if (got.name_length !== want.name_length)
      report_mismatch("name_length", got.name_length, want.name_length);
    if (got.complete !== want.complete)
      report_mismatch("complete", 16'(got.complete), 16'(want.complete));
    if (got.last !== want.last)
      report_mismatch("last", 16'(got.last), 16'(want.last));
  endtask

  // Offer one byte, wait for its transaction and record what it should cause.
  task automatic send_byte(input logic [7:0] b, input logic lb, input logic typed);
    tse_pkg::result_t r0;
    tse_pkg::result_t r1;
    int               n;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= lb;
    do @(posedge clk); while (!s_tready);
    sent_items++;
    n = predict_sni_step(b, lb, r0, r1);
    if (typed) begin
      expected_results.push_back(NO_SNI_VERDICT);
    end else begin
      if (n > 0) expected_results.push_back(r0);
      if (n > 1) expected_results.push_back(r1);
    end
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_bytes.size(); i++)
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0);
  endtask

  // Field lengths lean toward zero so that empty fields come up often.
  function automatic int pick_len(input int max_len);
    if ($urandom_range(3) == 0) return 0;
    return $urandom_range(max_len, 1);
  endfunction

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) pkt_bytes.push_back(8'($urandom));
  endtask

  task automatic push_word(input logic [15:0] w);
    pkt_bytes.push_back(w[15:8]);
    pkt_bytes.push_back(w[7:0]);
  endtask

  // Build a ClientHello with random content.
  task automatic build_hello();
    int          sid_len;
    int          cs_len;
    int          cm_len;
    int          n_ext;
    int          body;
    int          nm_len;
    int          nm_given;
    int          ext_start;
    int          ext_total;
    int          choice;
    bit          big_name;
    logic [15:0] ext_kind;
    pkt_bytes = {};
    big_name  = 1'b0;
    pkt_bytes.push_back(tse_pkg::RECORD_HANDSHAKE);
    push_random(tse_pkg::RECHDR_SKIP);
    pkt_bytes.push_back(tse_pkg::HS_CLIENT_HELLO);
    push_random(tse_pkg::FIXED_SKIP);
    sid_len = pick_len(32);
    pkt_bytes.push_back(8'(sid_len));
    push_random(sid_len);
    cs_len = pick_len(8);
    push_word(16'(cs_len));
    push_random(cs_len);
    cm_len = pick_len(4);
    pkt_bytes.push_back(8'(cm_len));
    push_random(cm_len);

    // Extensions: up to two of other types, then usually the server name.
    ext_start = pkt_bytes.size();
    push_word(16'h0000);
    n_ext = $urandom_range(2);
    for (int i = 0; i < n_ext; i++) begin
      ext_kind = $urandom_range(1) ? 16'($urandom_range(255, 1))
                                   : 16'($urandom_range(65535, 256));
      push_word(ext_kind);
      body = pick_len(6);
      push_word(16'(body));
      push_random(body);
    end
    if ($urandom_range(9) != 0) begin
      push_word(tse_pkg::EXT_SERVER_NAME);
      push_random(tse_pkg::SNIPRE_SKIP);
      big_name = ($urandom_range(9) == 0);
      nm_len   = big_name ? $urandom_range(65535) : pick_len(12);
      push_word(16'(nm_len));
      nm_given = big_name ? $urandom_range(5) : nm_len;
      if (nm_given > nm_len) nm_given = nm_len;
      push_random(nm_given);
    end

    // The extensions length is mostly right, sometimes zero or a random 1 to 20.
    ext_total = pkt_bytes.size() - ext_start - 2;
    choice    = $urandom_range(9);
    if (choice == 0) ext_total = 0;
    else if (choice == 1) ext_total = $urandom_range(20, 1);
    pkt_bytes[ext_start]     = 8'(ext_total >> 8);
    pkt_bytes[ext_start + 1] = 8'(ext_total);
    if (!big_name) push_random($urandom_range(3));
  endtask

  // Receiver: check each result transaction and choose the next m_tready.
  initial begin
    tse_pkg::result_t got;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.kind        = m_tuser;
        got.name_byte   = m_tdata[7:0];
        got.found       = m_tdata[8];
        got.name_offset = m_tdata[24:9];
        got.name_length = m_tdata[40:25];
        got.complete    = m_tdata[41];
        got.last        = m_tlast;
        if (expected_results.size() == 0)
          report_mismatch("unexpected result, name_byte", 16'(got.name_byte), 16'h0);
        else
          compare_result(got, expected_results.pop_front());
      end
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // Long receiver hold-off so that the output queue fills and stalls input.
  initial begin
    hold_off <= 1'b0;
    do @(posedge clk); while (!hold_req);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog on the whole run.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int cut;
    int idx;
    mismatches = 0;
    sent_items = 0;
    clear_sni_state();
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= 8'h00;
    s_tlast   <= 1'b0;
    hold_req  <= 1'b0;
    send_idle <= 25;
    recv_idle <= 63;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed rows.
    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed);

    // Random packets in three idling phases.
    sent_items = 0;
    while (sent_items < RANDOM_ITEMS) begin
      if (sent_items >= 2 * RANDOM_ITEMS / 3) begin
        send_idle <= 0;
        recv_idle <= 0;
        hold_req  <= 1'b1;
      end else if (sent_items >= RANDOM_ITEMS / 3) begin
        send_idle <= 63;
        recv_idle <= 25;
      end
      if ($urandom_range(4) != 0) begin
        build_hello();
        // Some packets are cut short, some carry a wrong type byte.
        if ($urandom_range(6) == 0) begin
          cut = $urandom_range(pkt_bytes.size(), 1);
          pkt_bytes = pkt_bytes[0:cut-1];
        end
        if ($urandom_range(11) == 0) begin
          idx = $urandom_range(1) ? 0 : 5;
          pkt_bytes[idx] = pkt_bytes[idx] ^ 8'($urandom_range(255, 1));
        end
      end else begin
        // Short noise packets, sometimes with a plausible start.
        pkt_bytes = {};
        push_random($urandom_range(8, 1));
        if ($urandom_range(2) == 0) pkt_bytes[0] = tse_pkg::RECORD_HANDSHAKE;
      end
      send_packet();
    end
    s_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
